/* hw/rtl/fbde_pkg.sv */
// fbde_pkg: shared types, constants and command codes of the frame buffer draw engine
// no dependencies
`default_nettype none
package fbde_pkg;
    localparam int SCREEN_WIDTH  = 240;
    localparam int SCREEN_HEIGHT = 240;
    localparam int PIX_COUNT     = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W        = $clog2(PIX_COUNT);
    localparam int COORD_W       = 12;
    localparam int CMD_W         = 128;
    localparam int S_TDATA_W     = 120;

    typedef enum logic [2:0] {
        ACT_PIXEL = 3'd0,
        ACT_HLINE = 3'd1,
        ACT_VLINE = 3'd2,
        ACT_RECT  = 3'd3,
        ACT_GLYPH = 3'd4,
        ACT_READ  = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DRAW,
        ST_READ,
        ST_WAIT,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture command and set up scan
        logic step;       // advance one pixel position
        logic clear_step; // advance clearing sweep
        logic read_req;   // issue anchor read
        logic finish;     // load result register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic cmd_ok;     // anchor on screen and valid action
        logic is_read;
        logic scan_done;  // last pixel position handled
    } dp_stat_t;
endpackage
`default_nettype wire

/* hw/rtl/framebuffer_draw_engine_unit.sv */
// framebuffer_draw_engine_unit: top level, sequencer plus datapath
// depends on fbde_pkg, fbde_ctrl, fbde_datapath
//
//  channel   | dir | fields
//  s_axis    | in  | tuser: action
//            |     | tdata: x_pos, y_pos, span, height, outline, color,
//            |     |        glyph_bits, scale
//  m_axis    | out | tdata: pixel_color, accepted
//
// after reset a sweep clears all 57600 pixels of the frame; no beat is taken meanwhile
// one command at a time; pixel positions are scanned one a cycle (at least one),
// and a read instead issues an anchor read
// a glyph scans 48*scale*scale positions, a filled rectangle its clipped area, an
// outline also the reach of thick bands left of and above the anchor
// the single write port of the frame memory sets the pixel rate
// a stalled result holds until taken; the next beat is taken afterward
`default_nettype none
module framebuffer_draw_engine_unit
    import fbde_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // action[2:0]
    input  wire logic [2:0]   s_axis_tuser,
    // x_pos[11:0], y_pos[23:12], span[33:24], height[43:34],
    // outline[51:44], color[67:52], glyph_bits[115:68], scale[119:116]
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // pixel_color[15:0], accepted[16]
    output logic [23:0]       m_axis_tdata
);
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [15:0] res_pixel;
    logic        res_accepted;
    logic [CMD_W-1:0] cmd_word;

    // internal command word: action in the low bits, then the data fields
    assign cmd_word = {5'd0, s_axis_tdata, s_axis_tuser};

    fbde_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (s_axis_tvalid && s_axis_tready),
        .out_fire  (m_axis_tvalid && m_axis_tready),
        .stat      (stat),
        .cmd       (cmd),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid)
    );

    fbde_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_data     (cmd_word),
        .cmd          (cmd),
        .stat         (stat),
        .res_pixel    (res_pixel),
        .res_accepted (res_accepted)
    );

    assign m_axis_tdata = {7'd0, res_accepted, res_pixel};
endmodule
`default_nettype wire

/* hw/rtl/fbde_datapath.sv */
// fbde_datapath: frame memory, pixel scan counters and write logic
// depends on fbde_pkg
`default_nettype none
module fbde_datapath
    import fbde_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [CMD_W-1:0] cmd_data,
    input  wire dp_cmd_t        cmd,
    output dp_stat_t            stat,
    output logic [15:0]         res_pixel,
    output logic                res_accepted
);
    // command fields
    logic [2:0]  act_reg;
    logic signed [12:0] x_reg, y_reg;
    logic [7:0]  thick_reg;
    logic [15:0] col_reg;
    logic [47:0] bits_reg;
    logic [3:0]  scale_reg;
    logic        ok_reg;

    // scan region and counters (signed, relative to the anchor)
    logic signed [13:0] u_reg, v_reg;      // scan offsets
    logic signed [13:0] uw_reg, vh_reg;    // scan extents
    logic signed [13:0] wd_reg, ht_reg;    // clipped rectangle size

    // glyph sub-counters
    logic [2:0] gcol_reg, grow_reg;
    logic [3:0] ga_reg, gb_reg;

    logic [ADDR_W-1:0] clr_reg;
    logic              clr_done_reg;
    logic [15:0]       mem [PIX_COUNT];
    logic [15:0]       rd_reg;

    logic [2:0]  in_act;
    logic signed [12:0] in_x, in_y;
    logic        in_ok;
    assign in_act = cmd_data[2:0];
    assign in_x   = {cmd_data[14], cmd_data[14:3]};
    assign in_y   = {cmd_data[26], cmd_data[26:15]};
    assign in_ok  = (in_act <= ACT_READ) && !in_x[12] && !in_y[12]
                 && (in_x < 13'(SCREEN_WIDTH)) && (in_y < 13'(SCREEN_HEIGHT));

    // clipped sizes for the incoming command
    logic signed [13:0] n_span, n_hgt, n_wd, n_ht;
    assign n_span = 14'(cmd_data[36:27]);
    assign n_hgt  = 14'(cmd_data[46:37]);
    assign n_wd = (14'(in_x) + n_span > 14'(SCREEN_WIDTH - 1))
                  ? 14'(SCREEN_WIDTH) - 14'(in_x) : n_span;
    assign n_ht = (14'(in_y) + n_hgt > 14'(SCREEN_HEIGHT - 1))
                  ? 14'(SCREEN_HEIGHT) - 14'(in_y) : n_hgt;

    // current pixel position and coverage test
    logic signed [13:0] px, py;
    logic               hit;
    logic [5:0]         gi;
    logic [2:0]         gcol;
    logic [2:0]         grow;
    logic signed [13:0] t14;
    assign t14 = 14'(thick_reg);

    always_comb
    begin
        px = 14'(x_reg) + u_reg;
        py = 14'(y_reg) + v_reg;
        hit = 1'b0;
        gi = '0; gcol = '0; grow = '0;
        case (act_reg)
            ACT_PIXEL: hit = 1'b1;
            ACT_HLINE, ACT_VLINE: hit = 1'b1;
            ACT_RECT:
            begin
                if (thick_reg == 8'd0)
                    hit = 1'b1;
                else
                begin
                    // scan from row min(y,y+ht-t), col min(x,x+wd-t); test bands
                    if ((v_reg < t14) && (u_reg >= 0) && (u_reg < wd_reg))
                        hit = 1'b1;
                    if ((v_reg >= ht_reg - t14) && (v_reg < ht_reg)
                        && (u_reg >= 0) && (u_reg < wd_reg))
                        hit = 1'b1;
                    if ((u_reg < t14) && (v_reg >= 0) && (v_reg < ht_reg))
                        hit = 1'b1;
                    if ((u_reg >= wd_reg - t14) && (u_reg < wd_reg)
                        && (v_reg >= 0) && (v_reg < ht_reg))
                        hit = 1'b1;
                    // band rows/cols are drawn as lines anchored at x or y,
                    // so their own anchor must be on screen
                    if ((14'(x_reg) >= 14'(SCREEN_WIDTH)) || (x_reg < 0))
                        hit = 1'b0;
                end
            end
            ACT_GLYPH:
            begin
                // u = column*scale + a, v = row*scale + b, decomposed by counters
                gcol = gcol_reg;
                grow = grow_reg;
                gi = 6'({gcol, 3'b000}) + 6'(grow);
                hit = bits_reg[6'd47 - gi];
            end
            default: hit = 1'b0;
        endcase
    end

    // per-band anchor checks for outline rows and columns
    logic band_ok;
    always_comb
    begin
        band_ok = 1'b1;
        if (act_reg == ACT_RECT && thick_reg != 8'd0)
        begin
            // row bands need x on screen (it is), column bands need y row on screen
            // row band draws as hline anchored (x, py): py on screen already checked
            // column band anchored (px, y): y on screen holds by acceptance
            band_ok = 1'b1;
        end
    end

    // last position of the scan
    logic last_u, last_v;
    always_comb
    begin
        if (act_reg == ACT_GLYPH)
        begin
            last_u = 1'b0;
            last_v = (gcol_reg == 3'd5) && (grow_reg == 3'd7)
                  && (ga_reg == scale_reg - 4'd1) && (gb_reg == scale_reg - 4'd1);
        end
        else
        begin
            last_u = (u_reg >= uw_reg - 14'sd1);
            last_v = last_u && (v_reg >= vh_reg - 14'sd1);
        end
    end

    logic signed [13:0] u0, v0;

    // command capture and scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg    <= 1'b0;
            act_reg   <= '0;
        end
        else if (cmd.load)
        begin
            ok_reg    <= in_ok;
            act_reg   <= in_act;
        end
    end

    always_comb
    begin
        u0 = '0;
        v0 = '0;
        if (in_act == ACT_RECT && cmd_data[54:47] != 8'd0)
        begin
            // bands can reach up or left of the anchor
            u0 = n_wd - 14'(cmd_data[54:47]);
            v0 = n_ht - 14'(cmd_data[54:47]);
            if (u0 > 0) u0 = '0;
            if (v0 > 0) v0 = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg     <= in_x;
            y_reg     <= in_y;
            thick_reg <= cmd_data[54:47];
            col_reg   <= cmd_data[70:55];
            bits_reg  <= cmd_data[118:71];
            scale_reg <= cmd_data[122:119];
            wd_reg    <= n_wd;
            ht_reg    <= n_ht;
            u_reg     <= u0;
            v_reg     <= v0;
            gcol_reg  <= '0;
            grow_reg  <= '0;
            ga_reg    <= '0;
            gb_reg    <= '0;
            case (in_act)
                ACT_HLINE:
                begin
                    uw_reg <= (14'(in_x) + n_span > 14'(SCREEN_WIDTH - 1))
                              ? 14'(SCREEN_WIDTH) - 14'(in_x) : n_span;
                    vh_reg <= 14'sd1;
                end
                ACT_VLINE:
                begin
                    uw_reg <= 14'sd1;
                    vh_reg <= (14'(in_y) + n_span > 14'(SCREEN_HEIGHT - 1))
                              ? 14'(SCREEN_HEIGHT) - 14'(in_y) : n_span;
                end
                ACT_RECT:
                begin
                    uw_reg <= (cmd_data[54:47] != 8'd0 && 14'(cmd_data[54:47]) > n_wd)
                              ? 14'(cmd_data[54:47]) : n_wd;
                    vh_reg <= (cmd_data[54:47] != 8'd0 && 14'(cmd_data[54:47]) > n_ht)
                              ? 14'(cmd_data[54:47]) : n_ht;
                end
                default:
                begin
                    uw_reg <= 14'sd1;
                    vh_reg <= 14'sd1;
                end
            endcase
        end
        else if (cmd.step)
        begin
            if (act_reg == ACT_GLYPH)
            begin
                if (gb_reg != scale_reg - 4'd1)
                    gb_reg <= gb_reg + 4'd1;
                else
                begin
                    gb_reg <= '0;
                    if (ga_reg != scale_reg - 4'd1)
                        ga_reg <= ga_reg + 4'd1;
                    else
                    begin
                        ga_reg <= '0;
                        if (grow_reg != 3'd7)
                            grow_reg <= grow_reg + 3'd1;
                        else
                        begin
                            grow_reg <= '0;
                            gcol_reg <= gcol_reg + 3'd1;
                        end
                    end
                end
            end
            else if (last_u)
            begin
                u_reg <= (thick_reg != 8'd0 && act_reg == ACT_RECT)
                         ? ((wd_reg - t14 > 0) ? 14'sd0 : wd_reg - t14) : 14'sd0;
                v_reg <= v_reg + 14'sd1;
            end
            else
                u_reg <= u_reg + 14'sd1;
        end
    end

    // glyph pixel position: column*scale + a, row*scale + b
    logic signed [13:0] gx, gy;
    assign gx = 14'(gcol_reg) * 14'(scale_reg) + 14'(ga_reg);
    assign gy = 14'(grow_reg) * 14'(scale_reg) + 14'(gb_reg);

    logic signed [13:0] fx, fy;
    logic               f_on;
    logic [ADDR_W-1:0]  faddr;
    assign fx = (act_reg == ACT_GLYPH) ? 14'(x_reg) + gx : px;
    assign fy = (act_reg == ACT_GLYPH) ? 14'(y_reg) + gy : py;
    assign f_on = (fx >= 0) && (fy >= 0) && (fx < 14'(SCREEN_WIDTH))
               && (fy < 14'(SCREEN_HEIGHT));
    assign faddr = ADDR_W'(fx) + ADDR_W'(fy) * ADDR_W'(SCREEN_WIDTH);

    logic empty_scan;
    assign empty_scan = (act_reg == ACT_GLYPH) ? (scale_reg == 4'd0)
                      : ((uw_reg <= 0) || (vh_reg <= 0));

    logic do_write;
    assign do_write = cmd.step && ok_reg && !empty_scan && hit && band_ok && f_on;

    // frame memory: clear sweep, draw writes, anchor read
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
            mem[clr_reg] <= 16'd0;
        else if (do_write)
            mem[faddr] <= col_reg;
        if (cmd.read_req)
            rd_reg <= mem[faddr];
    end

    // clearing sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            clr_done_reg <= 1'b0;
        end
        else if (cmd.clear_step)
        begin
            if (clr_reg == ADDR_W'(PIX_COUNT - 1))
                clr_done_reg <= 1'b1;
            else
                clr_reg <= clr_reg + 1'b1;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            res_accepted <= ok_reg;
            res_pixel    <= (ok_reg && act_reg == ACT_READ) ? rd_reg : 16'd0;
        end
    end

    assign stat.clear_done = clr_done_reg;
    assign stat.cmd_ok     = ok_reg;
    assign stat.is_read    = (act_reg == ACT_READ);
    assign stat.scan_done  = empty_scan || last_v;
endmodule
`default_nettype wire

/* hw/rtl/fbde_ctrl.sv */
// fbde_ctrl: command sequencer of the draw engine
// depends on fbde_pkg
`default_nettype none
module fbde_ctrl
    import fbde_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_fire,
    input  wire logic     out_fire,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd,
    output logic          in_ready,
    output logic          out_valid
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (stat.clear_done) state_next = ST_IDLE;
            ST_IDLE:  if (in_fire) state_next = ST_DRAW;
            ST_DRAW:
            begin
                if (!stat.cmd_ok)
                    state_next = ST_WAIT;
                else if (stat.is_read)
                    state_next = ST_READ;
                else if (stat.scan_done)
                    state_next = ST_WAIT;
            end
            ST_READ:  state_next = ST_WAIT;
            ST_WAIT:  state_next = ST_DONE;
            ST_DONE:  if (out_fire) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_CLEAR: cmd.clear_step = !stat.clear_done;
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_fire;
            end
            ST_DRAW:  cmd.step = stat.cmd_ok && !stat.is_read;
            ST_READ:  cmd.read_req = 1'b1;
            ST_WAIT:  cmd.finish = 1'b1;
            ST_DONE:  out_valid = 1'b1;
            default:  cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

/* hw/rtl/fbde_checker.sv */
// fbde_checker: port level checks of the draw engine, bound to the top level
// depends on fbde_pkg
`default_nettype none
module fbde_checker
    import fbde_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_axis_tvalid,
    input wire logic             s_axis_tready,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [23:0]      m_axis_tdata
);
    // one command at a time
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");

    // result beat holds while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");

    // a taken input closes the input side next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second beat taken");

    // pixel color is zero when not accepted
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[16] |-> m_axis_tdata[15:0] == 16'd0)
        else $error("color on rejected command");
endmodule

bind framebuffer_draw_engine_unit fbde_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
